/* src/assert_macros.svh */
// Assertion macros used by the checker file of the matrix multiply unit.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* src/imm_pkg.sv */
// Shared constants, types and helper functions of the integer matrix multiply unit.
// Depends on nothing; every other file but assert_macros.svh imports it.
package imm_pkg;

   localparam int MAX_DIM    = 8;
   localparam int ELEM_WIDTH = 16;

   localparam int IN_ELEM_W = 16;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 35;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic              en_a;
      logic              en_b;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_WIDTH-1:0] data;
   } imm_wr_type;

   typedef struct packed {
      logic              vld;
      logic              first;
      logic              last;
      logic [ADDR_W-1:0] a_addr;
      logic [ADDR_W-1:0] b_addr;
   } imm_rd_type;

   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } imm_tag_type;

   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } imm_out_type;

   // Map a register value onto 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

   // Row-major address of a matrix element.
   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_DIM + int'(col));
   endfunction

endpackage

/* src/imm_store.sv */
// Element stores for matrices A and B: one write port, one registered read per matrix.
// Depends on imm_pkg.
module imm_store
   import imm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  imm_wr_type            wr,
   input  imm_rd_type            rd,
   output logic [ELEM_WIDTH-1:0] a_data,
   output logic [ELEM_WIDTH-1:0] b_data,
   output imm_tag_type           tag
);

   logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
   logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
   logic [ELEM_WIDTH-1:0] a_data_ff;
   logic [ELEM_WIDTH-1:0] b_data_ff;
   imm_tag_type           tag_ff;
   imm_tag_type           tag_in;

   always_ff @(posedge clock) begin
      if (wr.en_a) begin
         mem_a[wr.addr] <= wr.data;
      end
      if (wr.en_b) begin
         mem_b[wr.addr] <= wr.data;
      end
      a_data_ff <= mem_a[rd.a_addr];
      b_data_ff <= mem_b[rd.b_addr];
   end

   assign tag_in = '{vld: rd.vld, first: rd.first, last: rd.last};

   // Carry the term tags alongside the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign a_data = a_data_ff;
   assign b_data = b_data_ff;
   assign tag    = tag_ff;

endmodule

/* src/imm_mac.sv */
// Shared multiply-accumulate unit: one registered product, then a 35-bit running sum.
// Depends on imm_pkg.
module imm_mac
   import imm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ELEM_WIDTH-1:0]    a_data,
   input  logic [ELEM_WIDTH-1:0]    b_data,
   input  imm_tag_type              tag,
   output logic signed [PROD_W-1:0] acc,
   output logic                     done
);

   logic signed [2*ELEM_WIDTH-1:0] prod_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_in;
   imm_tag_type                    tag_ff;
   logic signed [PROD_W-1:0]       acc_ff;
   logic signed [PROD_W-1:0]       acc_in;
   logic signed [PROD_W-1:0]       term;
   logic                           done_ff;

   assign prod_in = $signed(a_data) * $signed(b_data);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Extend or wrap the product to the sum width; restart on the first term.
   assign term   = PROD_W'(prod_ff);
   assign acc_in = tag_ff.first ? term : acc_ff + term;

   always_ff @(posedge clock) begin
      if (tag_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         tag_ff  <= tag;
         done_ff <= tag_ff.vld & tag_ff.last;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

/* src/imm_seq.sv */
// Sequencer: walks row, column and inner index, issues reads, hands finished sums out.
// Depends on imm_pkg.
module imm_seq
   import imm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] n_rows,
   input  logic [DIM_W-1:0] n_inner,
   input  logic [DIM_W-1:0] n_cols,
   input  logic             mac_done,
   input  logic             out_free,
   output logic             busy,
   output imm_rd_type       rd,
   output imm_out_type      out
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_PUSH  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] rm1, km1, cm1;
   logic             k_last, i_last, j_last;

   assign rm1 = n_rows - DIM_W'(1);
   assign km1 = n_inner - DIM_W'(1);
   assign cm1 = n_cols - DIM_W'(1);
   assign i_last = (i_ff == rm1[IDX_W-1:0]);
   assign j_last = (j_ff == cm1[IDX_W-1:0]);
   assign k_last = (k_ff == km1[IDX_W-1:0]);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      out      = '{load: 1'b0, row: i_ff, col: j_ff, last: i_last & j_last};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (k_last) begin
               k_in     = '0;
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               out.load = 1'b1;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = S_IDLE;
                  end else begin
                     i_in     = i_ff + IDX_W'(1);
                     state_in = S_RUN;
                  end
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = S_RUN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // Issue one term A[i][k] * B[k][j] per cycle while running.
   assign rd = '{vld:    (state_ff == S_RUN),
                 first:  (k_ff == '0),
                 last:   k_last,
                 a_addr: elem_addr(i_ff, k_ff),
                 b_addr: elem_addr(k_ff, j_ff)};

endmodule

/* src/integer_matrix_multiply_unit.sv */
// Integer matrix multiply unit: top level with configuration registers and result register.
// Depends on imm_pkg, imm_store, imm_mac and imm_seq.
//
// Use: write words on the req_ channel load A (op write A) or B (op write B) one element
// each, at row_index/col_index; such words give no result. A word with
// op compute emits every element of A times B in row-major order on the rsp_ channel,
// rsp_last marking the final one. Op code three is dropped.
// Rate: one shared multiplier and accumulator do all the work, one term per cycle while
// the sequencer runs; each product element goes through the inner_dim reads, memory read,
// multiply, accumulate, then the hand-off, which waits while the result register is full.
// req_stall stays high for the whole compute run.
// csr_ writes set rows_a, inner_dim, cols_b (0 acts as 1, above 8 as 8); write them only
// while idle. Reset sets all three to 8 and clears control state; the element stores
// hold garbage until written. When the receiver stalls, the result register holds its
// word and the sequencer waits before handing out the next element.
module integer_matrix_multiply_unit
   import imm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_op,
   input  logic [IDX_W-1:0]         req_row_index,
   input  logic [IDX_W-1:0]         req_col_index,
   input  logic signed [IN_ELEM_W-1:0] req_element,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [IDX_W-1:0]         rsp_out_row,
   output logic [IDX_W-1:0]         rsp_out_col,
   output logic signed [PROD_W-1:0] rsp_product,
   output logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIM_W-1:0]         csr_wdata
);

   logic [DIM_W-1:0]         rows_a_ff, inner_dim_ff, cols_b_ff;
   logic                     req_accept;
   logic                     in_range;
   imm_wr_type               wr;
   imm_rd_type               rd;
   imm_tag_type              tag;
   imm_out_type              out;
   logic [ELEM_WIDTH-1:0]    a_data, b_data;
   logic signed [PROD_W-1:0] acc;
   logic                     mac_done;
   logic                     busy;
   logic                     out_free;

   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [PROD_W-1:0] rsp_product_ff;
   logic                     rsp_last_ff;

   // Configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROWS_A:    rows_a_ff    <= csr_wdata;
            CSR_INNER_DIM: inner_dim_ff <= csr_wdata;
            CSR_COLS_B:    cols_b_ff    <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Hold off new words for the whole compute run.
   assign req_stall  = busy;
   assign req_accept = req_valid & ~req_stall;

   // Drop writes that fall outside the store.
   assign in_range = ({1'b0, req_row_index} < DIM_W'(MAX_DIM)) &&
                     ({1'b0, req_col_index} < DIM_W'(MAX_DIM));

   assign wr = '{en_a: req_accept & in_range & (req_op == OP_WR_A),
                 en_b: req_accept & in_range & (req_op == OP_WR_B),
                 addr: elem_addr(req_row_index, req_col_index),
                 data: ELEM_WIDTH'(req_element)};

   imm_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd     (rd),
      .a_data (a_data),
      .b_data (b_data),
      .tag    (tag)
   );

   imm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .a_data (a_data),
      .b_data (b_data),
      .tag    (tag),
      .acc    (acc),
      .done   (mac_done)
   );

   imm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept & (req_op == OP_MUL)),
      .n_rows   (clamp_dim(rows_a_ff)),
      .n_inner  (clamp_dim(inner_dim_ff)),
      .n_cols   (clamp_dim(cols_b_ff)),
      .mac_done (mac_done),
      .out_free (out_free),
      .busy     (busy),
      .rd       (rd),
      .out      (out)
   );

   // The result register is free when empty or being taken this cycle.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out.load) begin
         rsp_row_ff     <= out.row;
         rsp_col_ff     <= out.col;
         rsp_product_ff <= acc;
         rsp_last_ff    <= out.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* src/imm_checker.sv */
// Port-level checker for the integer matrix multiply unit, bound to the top level.
// Depends on imm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imm_checker
   import imm_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [OP_W-1:0]          req_op,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [IDX_W-1:0]         rsp_out_row,
   input logic [IDX_W-1:0]         rsp_out_col,
   input logic signed [PROD_W-1:0] rsp_product,
   input logic                     rsp_last
);

   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_product) && $stable(rsp_last))

   // Reset empties the result register.
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A compute word blocks the input channel in the next cycle.
   `ASSERT_NEXT(a_mul_busy, clock, reset, req_valid && !req_stall && req_op == OP_MUL, req_stall)

   // A write word while empty never makes a result appear.
   `ASSERT_NEXT(a_wr_quiet, clock, reset, req_valid && !req_stall && req_op != OP_MUL && !rsp_valid, !rsp_valid)

   // Right after the last element of a run only the first element of the next run may follow.
   `ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_last && !rsp_stall, !rsp_valid || (rsp_out_row == '0 && rsp_out_col == '0))

endmodule

bind integer_matrix_multiply_unit imm_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_op      (req_op),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_row (rsp_out_row),
   .rsp_out_col (rsp_out_col),
   .rsp_product (rsp_product),
   .rsp_last    (rsp_last)
);

/* tb/imm_tb_pkg.sv */
// Product tracker for the integer matrix multiply unit testbench: keeps its own copy of
// the dimension registers and of both element stores, and predicts every product word.
// Depends on imm_pkg.
package imm_tb_pkg;
   import imm_pkg::*;

   // Op code that the unit drops without a result.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [PROD_W-1:0] product;
      logic              last;
   } product_elem_type;

   // Dimension that a register value stands for: zero acts as one, large values saturate.
   function automatic int dim_used(input logic [DIM_W-1:0] d);
      if (d == '0) begin
         return 1;
      end
      if (int'(d) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(d);
   endfunction

   class product_tracker;
      logic [DIM_W-1:0]             rows_cfg;
      logic [DIM_W-1:0]             inner_cfg;
      logic [DIM_W-1:0]             cols_cfg;
      logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
      logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
      product_elem_type             pending_products [$];
      int                           errors;

      function new();
         rows_cfg  = DIM_RESET;
         inner_cfg = DIM_RESET;
         cols_cfg  = DIM_RESET;
         errors    = 0;
      endfunction

      function void set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                             input logic [DIM_W-1:0] c);
         rows_cfg  = r;
         inner_cfg = k;
         cols_cfg  = c;
      endfunction

      function int pending_count();
         return pending_products.size();
      endfunction

      // Queue every element of A times B in row-major order.
      function void compute_product();
         int                             nr, nk, nc, i, j, k;
         logic signed [PROD_W-1:0]       acc;
         logic signed [2*ELEM_WIDTH-1:0] term;
         product_elem_type               e;
         nr = dim_used(rows_cfg);
         nk = dim_used(inner_cfg);
         nc = dim_used(cols_cfg);
         for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
               acc = '0;
               for (k = 0; k < nk; k++) begin
                  term = a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
                  acc  = acc + term;
               end
               e.row     = IDX_W'(i);
               e.col     = IDX_W'(j);
               e.product = acc;
               e.last    = (i == nr - 1) && (j == nc - 1);
               pending_products.push_back(e);
            end
         end
      endfunction

      function void note_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic signed [IN_ELEM_W-1:0] elem);
         int addr;
         addr = int'(row) * MAX_DIM + int'(col);
         case (op)
            OP_WR_A: a_mem[addr] = elem;
            OP_WR_B: b_mem[addr] = elem;
            OP_MUL:  compute_product();
            default: ;
         endcase
      endfunction

      function void compare_field(input string field, input logic signed [63:0] want,
                                  input logic signed [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                                 input logic signed [PROD_W-1:0] product, input logic last);
         product_elem_type e;
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected product word: expected none, actual row %0d col %0d %0d",
                     $time, row, col, product);
            errors++;
            return;
         end
         e = pending_products.pop_front();
         compare_field("out_row", e.row, row);
         compare_field("out_col", e.col, col);
         compare_field("product", $signed(e.product), product);
         compare_field("last", e.last, last);
      endfunction
   endclass

endpackage

/* tb/tb_top.sv */
// Top level of the integer matrix multiply unit testbench: clock, reset, stimulus, response
// stalling, monitors and watchdog around the unit.
// Depends on imm_pkg, imm_tb_pkg and the unit's RTL.
module tb_top;
   import imm_pkg::*;
   import imm_tb_pkg::*;

   localparam int HALF_PERIOD    = 5;
   // Longest quiet stretch allowed: a held-off receiver plus a slow product element.
   localparam int WATCHDOG_LIMIT = 4000;
   // Settling time for the unit after the last expected product word.
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_WORDS   = 220;
   localparam int FULL_ROUND     = 3;
   localparam int PRESSURE_ROUND = 4;
   // Idling per round, cycled: none, sender only, receiver only, both.
   localparam int SEND_IDLE_PCT [4] = '{0, 68, 0, 27};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 68, 27};

   logic                        clock         = 1'b0;
   logic                        reset         = 1'b1;
   logic                        req_valid     = 1'b0;
   logic                        req_stall;
   logic [OP_W-1:0]             req_op        = OP_WR_A;
   logic [IDX_W-1:0]            req_row_index = '0;
   logic [IDX_W-1:0]            req_col_index = '0;
   logic signed [IN_ELEM_W-1:0] req_element   = '0;
   logic                        rsp_valid;
   logic                        rsp_stall     = 1'b0;
   logic [IDX_W-1:0]            rsp_out_row;
   logic [IDX_W-1:0]            rsp_out_col;
   logic signed [PROD_W-1:0]    rsp_product;
   logic                        rsp_last;
   logic                        csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index     = CSR_ROWS_A;
   logic [DIM_W-1:0]            csr_wdata     = DIM_RESET;

   product_tracker products;

   // Entries the stimulus has loaded; a compute only ever reads these.
   bit               a_loaded [DEPTH];
   bit               b_loaded [DEPTH];
   logic [DIM_W-1:0] cfg_rows  = DIM_RESET;
   logic [DIM_W-1:0] cfg_inner = DIM_RESET;
   logic [DIM_W-1:0] cfg_cols  = DIM_RESET;
   int               word_count      = 0;
   int               sender_idle_pct = 0;
   int               rsp_stall_pct   = 0;
   int               hold_serial     = 0;
   int               hold_seen       = 0;
   int               hold_left       = 0;
   int               quiet_cycles    = 0;

   integer_matrix_multiply_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_element   (req_element),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_product   (rsp_product),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Monitor both channels at the edge; a word moves when valid is high and stall low.
   // Count edges at which nothing moves for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            products.note_word(req_op, req_row_index, req_col_index, req_element);
         end
         if (rsp_valid && !rsp_stall) begin
            products.check_result(rsp_out_row, rsp_out_col, rsp_product, rsp_last);
         end
      end
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: stall at random, or hold off for a long stretch when one is requested.
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen = hold_serial;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (int'($urandom_range(99, 0)) < rsp_stall_pct);
      end
   end

   // Watchdog: end the run if the unit stops moving words.
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Element values, weighted toward the extremes of the signed range.
   function automatic logic signed [IN_ELEM_W-1:0] pick_element();
      case ($urandom_range(7, 0))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '0;
         3:       return '1;
         default: return IN_ELEM_W'($urandom);
      endcase
   endfunction

   // Offer one word and hold it until accepted. Called and left at a rising edge;
   // valid stays high into the next word unless an idle gap is drawn.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col,
                            input logic signed [IN_ELEM_W-1:0] elem);
      while (int'($urandom_range(99, 0)) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_row_index <= row;
      req_col_index <= col;
      req_element   <= elem;
      if (op == OP_WR_A) begin
         a_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      end
      if (op == OP_WR_B) begin
         b_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      end
      if (op != OP_UNUSED) begin
         word_count++;
      end
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_compute();
      send_word(OP_MUL, IDX_W'($urandom), IDX_W'($urandom), IN_ELEM_W'($urandom));
   endtask

   // Drop valid, wait for every expected product word, then let the unit settle.
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (products.pending_count() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // Write all three dimension registers; only called while the unit is idle.
   task automatic write_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                             input logic [DIM_W-1:0] c);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROWS_A;
      csr_wdata <= r;
      @(posedge clock);
      csr_index <= CSR_INNER_DIM;
      csr_wdata <= k;
      @(posedge clock);
      csr_index <= CSR_COLS_B;
      csr_wdata <= c;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_rows  = r;
      cfg_inner = k;
      cfg_cols  = c;
      products.set_dims(r, k, c);
   endtask

   // Random writes to either matrix anywhere in the store, with a few dropped op codes.
   task automatic send_noise(input int count);
      int               n;
      logic [OP_W-1:0]  op;
      for (n = 0; n < count; n++) begin
         case ($urandom_range(7, 0))
            0:       op = OP_UNUSED;
            1, 2, 3: op = OP_WR_A;
            default: op = OP_WR_B;
         endcase
         send_word(op, IDX_W'($urandom_range(7, 0)), IDX_W'($urandom_range(7, 0)),
                   pick_element());
      end
   endtask

   // Load every operand entry the next compute reads that has never been written.
   task automatic fill_operands();
      int nr, nk, nc, i, j, k;
      nr = dim_used(cfg_rows);
      nk = dim_used(cfg_inner);
      nc = dim_used(cfg_cols);
      for (i = 0; i < nr; i++) begin
         for (k = 0; k < nk; k++) begin
            if (!a_loaded[i * MAX_DIM + k]) begin
               send_word(OP_WR_A, IDX_W'(i), IDX_W'(k), pick_element());
            end
         end
      end
      for (k = 0; k < nk; k++) begin
         for (j = 0; j < nc; j++) begin
            if (!b_loaded[k * MAX_DIM + j]) begin
               send_word(OP_WR_B, IDX_W'(k), IDX_W'(j), pick_element());
            end
         end
      end
   endtask

   initial begin
      int k;
      int round;
      int words_at_start;
      products = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Largest product: one row of A and one column of B, all at the most negative value,
      // so the single element is eight times 2^30.
      write_dims(4'd1, 4'd8, 4'd1);
      for (k = 0; k < MAX_DIM; k++) begin
         send_word(OP_WR_A, '0, IDX_W'(k), 16'sh8000);
         send_word(OP_WR_B, IDX_W'(k), '0, 16'sh8000);
      end
      send_word(OP_MUL, '1, '1, 16'sh7fff);
      // Unused op code with every field bit set: the unit must drop it.
      send_word(OP_UNUSED, '1, '1, '1);
      // Store outside the current dimensions; a later full-size compute reads it.
      send_word(OP_WR_A, 3'd5, 3'd6, 16'sh3039);
      drain(SETTLE_CYCLES);

      // Out-of-range dimensions: zero acts as one, fifteen saturates to eight.
      // Products mix the most negative and most positive elements.
      write_dims(4'd0, 4'd0, 4'd15);
      for (k = 1; k < MAX_DIM; k++) begin
         send_word(OP_WR_B, '0, IDX_W'(k), 16'sh7fff);
      end
      send_compute();
      drain(SETTLE_CYCLES);

      // Random rounds: new dimensions, some noise, then well-formed load-and-compute runs.
      words_at_start = word_count;
      round = 0;
      while (word_count < words_at_start + RANDOM_WORDS) begin
         sender_idle_pct = SEND_IDLE_PCT[round % 4];
         rsp_stall_pct   = RECV_STALL_PCT[round % 4];
         if (round == FULL_ROUND) begin
            write_dims(4'd8, 4'd15, 4'd9);
         end else if (round == PRESSURE_ROUND) begin
            write_dims(4'd3, 4'd3, 4'd3);
         end else if ($urandom_range(4, 0) == 0) begin
            write_dims(DIM_W'($urandom_range(15, 0)), DIM_W'($urandom_range(15, 0)),
                       DIM_W'($urandom_range(15, 0)));
         end else begin
            write_dims(DIM_W'($urandom_range(4, 1)), DIM_W'($urandom_range(4, 1)),
                       DIM_W'($urandom_range(4, 1)));
         end
         // Hold the receiver off while the sender keeps offering: the result path
         // backs up and the unit must stall its input.
         if (round == PRESSURE_ROUND) begin
            hold_serial++;
         end
         send_noise($urandom_range(6, 0));
         fill_operands();
         send_compute();
         if (round == PRESSURE_ROUND || $urandom_range(1, 0) == 1) begin
            send_noise($urandom_range(4, 0));
            fill_operands();
            send_compute();
         end
         drain(SETTLE_CYCLES);
         round++;
      end

      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      drain(4 * SETTLE_CYCLES);
      if (products.errors == 0 && products.pending_count() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
